// ===== rtl/etx_pkg.sv =====
// shared types, constants and crc helper for the ethernet transmit framer
package etx_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int HDR_W       = 112;

	localparam logic [7:0]  PRE_BYTE = 8'h55;
	localparam logic [7:0]  SFD_BYTE = 8'hD5;
	localparam logic [7:0]  GAP_BYTE = 8'h07;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [3:0] PRE_LAST_IDX = 4'd7;
	localparam logic [3:0] HDR_LAST_IDX = 4'd13;
	localparam logic [3:0] FCS_LAST_IDX = 4'd3;

	typedef enum logic [2:0] {
		KIND_PRE = 3'd0,
		KIND_HDR = 3'd1,
		KIND_PAY = 3'd2,
		KIND_FCS = 3'd3,
		KIND_GAP = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_CMD,
		ST_PRE,
		ST_HDR,
		ST_PAY,
		ST_FCS,
		ST_GAP
	} state_t;

	typedef enum logic [1:0] {
		REG_DEST = 2'd0,
		REG_SRC  = 2'd1,
		REG_TYPE = 2'd2,
		REG_GAP  = 2'd3
	} reg_t;

	typedef struct packed {
		logic       idle;
		logic       start;
		logic       last;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/etx_front.sv =====
// front end: accepts input beats, tracks frame state and builds commands
module etx_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,   // data_byte
	input  logic           s_tlast,   // frame_last
	input  logic           s_tuser,   // action
	input  logic           q_ready,
	output logic           q_push,
	output etx_pkg::cmd_t  q_cmd
);

	logic frame_open_q;

	assign s_tready = q_ready;
	assign q_push   = s_tvalid & q_ready;

	always_comb begin
		q_cmd.idle  = s_tuser;
		q_cmd.start = ~s_tuser & ~frame_open_q;
		q_cmd.last  = ~s_tuser & s_tlast;
		q_cmd.data  = s_tdata;
	end

	// idle beats leave the frame state alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (q_push && !s_tuser) begin
			frame_open_q <= ~s_tlast;
		end
	end

endmodule

// ===== rtl/etx_queue.sv =====
// short command queue between front end and byte sequencer
module etx_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  etx_pkg::cmd_t  push_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output etx_pkg::cmd_t  head
);

	etx_pkg::cmd_t                    mem_q [etx_pkg::QUEUE_DEPTH];
	logic [etx_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [etx_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [etx_pkg::QUEUE_AW:0]       count_q;

	assign ready = (count_q != (etx_pkg::QUEUE_AW+1)'(etx_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");
`endif

endmodule

// ===== rtl/etx_back.sv =====
// back end: byte sequencer with crc and registered output stage
module etx_back #(
	parameter int GAP_W = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  etx_pkg::cmd_t                head,
	output logic                         q_pop,
	input  logic [etx_pkg::HDR_W-1:0]    hdr_bytes,
	input  logic [GAP_W-1:0]             gap_count,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,
	output logic [2:0]                   m_tuser,
	output logic                         m_tlast
);

	etx_pkg::state_t  state_q;
	etx_pkg::state_t  state_d;
	logic [3:0]       cnt_q;
	logic [GAP_W-1:0] gap_left_q;
	logic [31:0]      crc_q;

	logic             m_valid_q;
	logic [7:0]       m_data_q;
	logic [2:0]       m_kind_q;
	logic             m_last_q;

	logic             adv;
	logic [7:0]       byte_c;
	etx_pkg::kind_t   kind_c;
	logic             last_c;
	logic             pop_c;
	logic             crc_en_c;
	logic [3:0]       hdr_idx;
	logic [31:0]      fcs_val;

	assign adv     = q_valid & (~m_valid_q | m_tready);
	assign hdr_idx = etx_pkg::HDR_LAST_IDX - cnt_q;
	assign fcs_val = ~crc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			etx_pkg::ST_CMD: begin
				if (head.idle) begin
					state_d = etx_pkg::ST_CMD;
				end else if (head.start) begin
					state_d = etx_pkg::ST_PRE;
				end else if (head.last) begin
					state_d = etx_pkg::ST_FCS;
				end
			end
			etx_pkg::ST_PRE: begin
				if (cnt_q == etx_pkg::PRE_LAST_IDX) state_d = etx_pkg::ST_HDR;
			end
			etx_pkg::ST_HDR: begin
				if (cnt_q == etx_pkg::HDR_LAST_IDX) state_d = etx_pkg::ST_PAY;
			end
			etx_pkg::ST_PAY: begin
				state_d = head.last ? etx_pkg::ST_FCS : etx_pkg::ST_CMD;
			end
			etx_pkg::ST_FCS: begin
				if (cnt_q == etx_pkg::FCS_LAST_IDX) begin
					state_d = (gap_count == '0) ? etx_pkg::ST_CMD : etx_pkg::ST_GAP;
				end
			end
			etx_pkg::ST_GAP: begin
				if (gap_left_q == GAP_W'(1)) state_d = etx_pkg::ST_CMD;
			end
			default: state_d = etx_pkg::ST_CMD;
		endcase
	end

	// byte, kind and end-of-run for the current step
	always_comb begin
		byte_c   = head.data;
		kind_c   = etx_pkg::KIND_PAY;
		last_c   = 1'b0;
		pop_c    = 1'b0;
		crc_en_c = 1'b0;
		unique case (state_q)
			etx_pkg::ST_CMD: begin
				if (head.idle) begin
					byte_c = etx_pkg::GAP_BYTE;
					kind_c = etx_pkg::KIND_GAP;
					last_c = 1'b1;
					pop_c  = 1'b1;
				end else if (head.start) begin
					byte_c = etx_pkg::PRE_BYTE;
					kind_c = etx_pkg::KIND_PRE;
				end else begin
					crc_en_c = 1'b1;
					last_c   = ~head.last;
					pop_c    = ~head.last;
				end
			end
			etx_pkg::ST_PRE: begin
				byte_c = (cnt_q == etx_pkg::PRE_LAST_IDX) ? etx_pkg::SFD_BYTE
				                                          : etx_pkg::PRE_BYTE;
				kind_c = etx_pkg::KIND_PRE;
			end
			etx_pkg::ST_HDR: begin
				byte_c   = hdr_bytes[{hdr_idx, 3'b000} +: 8];
				kind_c   = etx_pkg::KIND_HDR;
				crc_en_c = 1'b1;
			end
			etx_pkg::ST_PAY: begin
				crc_en_c = 1'b1;
				last_c   = ~head.last;
				pop_c    = ~head.last;
			end
			etx_pkg::ST_FCS: begin
				// fcs goes out least significant byte first
				byte_c = fcs_val[{cnt_q[1:0], 3'b000} +: 8];
				kind_c = etx_pkg::KIND_FCS;
				if (cnt_q == etx_pkg::FCS_LAST_IDX && gap_count == '0) begin
					last_c = 1'b1;
					pop_c  = 1'b1;
				end
			end
			etx_pkg::ST_GAP: begin
				byte_c = etx_pkg::GAP_BYTE;
				kind_c = etx_pkg::KIND_GAP;
				if (gap_left_q == GAP_W'(1)) begin
					last_c = 1'b1;
					pop_c  = 1'b1;
				end
			end
			default: begin
				byte_c = head.data;
			end
		endcase
	end

	assign q_pop = adv & pop_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= etx_pkg::ST_CMD;
			cnt_q      <= '0;
			gap_left_q <= '0;
			crc_q      <= etx_pkg::CRC_INIT;
		end else if (adv) begin
			state_q <= state_d;
			if (state_q == etx_pkg::ST_CMD && state_d == etx_pkg::ST_PRE) begin
				// the command step already sent preamble byte zero
				cnt_q <= 4'd1;
			end else if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_d == etx_pkg::ST_GAP && state_q != etx_pkg::ST_GAP) begin
				gap_left_q <= gap_count;
			end else if (state_q == etx_pkg::ST_GAP) begin
				gap_left_q <= gap_left_q - 1'b1;
			end
			if (state_q == etx_pkg::ST_PRE) begin
				crc_q <= etx_pkg::CRC_INIT;
			end else if (crc_en_c) begin
				crc_q <= etx_pkg::crc_byte(crc_q, byte_c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= byte_c;
			m_kind_q <= kind_c;
			m_last_q <= last_c;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != etx_pkg::ST_CMD |-> q_valid)
		else $error("command left the queue before its bytes were sent");
	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == etx_pkg::ST_GAP |-> gap_left_q != '0)
		else $error("gap burst running with zero bytes left");
`endif

endmodule

// ===== rtl/ethernet_frame_transmit_builder.sv =====
// top level of the ethernet transmit framer: config registers, front end, queue, sequencer
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata data_byte, tlast frame_last, tuser action
//  m_*     | out | m_tvalid/m_tready  | tdata out_byte, tuser byte_kind, tlast run_last
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
//  the sequencer emits one byte per cycle unless the queue is empty or the output stalls;
//  bytes per item: mid-frame payload 1, frame start 23, frame end 5 plus gap count, idle 1
//  input accepts while the 4-entry command queue has room, so bursts stall the input
//  output is a single register stage; m_tready low stalls the sequencer while it is full
//  reset is asynchronous, active low; no clearing pass, ready right after reset
module ethernet_frame_transmit_builder #(
	parameter int MAX_GAP_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tlast,
	input  logic        s_tuser,    // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] out_byte
	output logic        m_tlast,
	output logic [2:0]  m_tuser,    // [2:0] byte_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int GAP_W = (MAX_GAP_BYTES > 0) ? $clog2(MAX_GAP_BYTES + 1) : 1;

	logic [47:0]      dest_q;
	logic [47:0]      src_q;
	logic [15:0]      type_q;
	logic [5:0]       gap_q;
	logic [GAP_W-1:0] gap_sat;

	logic             q_ready;
	logic             q_push;
	etx_pkg::cmd_t    q_cmd;
	logic             q_pop;
	logic             q_valid;
	etx_pkg::cmd_t    q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q <= '0;
			src_q  <= '0;
			type_q <= '0;
			gap_q  <= 6'd12;
		end else if (cfg_valid) begin
			unique case (etx_pkg::reg_t'(cfg_index))
				etx_pkg::REG_DEST: dest_q <= cfg_data;
				etx_pkg::REG_SRC:  src_q  <= cfg_data;
				etx_pkg::REG_TYPE: type_q <= cfg_data[15:0];
				etx_pkg::REG_GAP:  gap_q  <= cfg_data[5:0];
				default:           dest_q <= dest_q;
			endcase
		end
	end

	assign gap_sat = (gap_q > 6'(MAX_GAP_BYTES)) ? GAP_W'(MAX_GAP_BYTES) : GAP_W'(gap_q);

	etx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	etx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.ready    (q_ready),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	etx_back #(
		.GAP_W (GAP_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (q_head),
		.q_pop     (q_pop),
		.hdr_bytes ({dest_q, src_q, type_q}),
		.gap_count (gap_sat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	a_run_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == etx_pkg::KIND_PAY
			|| m_tuser == etx_pkg::KIND_FCS || m_tuser == etx_pkg::KIND_GAP))
		else $error("run ended inside preamble or header");
`endif

endmodule
